FILE: design/phfc_pkg.sv
// ----------------------------------------------------------------------------
// Heartbeat framer package
// Frame layout, byte codes and the CRC16-CCITT byte update shared by the
// heartbeat framer.
// ----------------------------------------------------------------------------
package phfc_pkg;

   typedef logic [4:0]  frame_idx_type;
   typedef logic [7:0]  byte_type;
   typedef logic [15:0] crc_type;

   localparam byte_type SYNC_BYTE    = 8'hAA;
   localparam byte_type FAMILY_BYTE  = 8'h58;
   localparam byte_type VERSION_BYTE = 8'h01;
   localparam byte_type PING_BYTE    = 8'h01;
   localparam byte_type ZERO_BYTE    = 8'h00;

   localparam crc_type    CRC_POLY  = 16'h1021;
   localparam crc_type    CRC_INIT  = 16'hFFFF;
   localparam logic [31:0] US_PER_MS = 32'd1000;
   localparam logic [15:0] PERIOD_RESET = 16'd1000;

   localparam frame_idx_type POS_SYNC     = 5'd0;
   localparam frame_idx_type POS_FAMILY   = 5'd1;
   localparam frame_idx_type POS_VERSION  = 5'd2;
   localparam frame_idx_type POS_PING     = 5'd3;
   localparam frame_idx_type POS_RSV0     = 5'd4;
   localparam frame_idx_type POS_RSV1     = 5'd5;
   localparam frame_idx_type POS_SEQ0     = 5'd6;
   localparam frame_idx_type POS_SEQ1     = 5'd7;
   localparam frame_idx_type POS_SEQ2     = 5'd8;
   localparam frame_idx_type POS_SEQ3     = 5'd9;
   localparam frame_idx_type POS_RSV2     = 5'd10;
   localparam frame_idx_type POS_RSV3     = 5'd11;
   localparam frame_idx_type POS_TS0      = 5'd12;
   localparam frame_idx_type POS_TS1      = 5'd13;
   localparam frame_idx_type POS_TS2      = 5'd14;
   localparam frame_idx_type POS_TS3      = 5'd15;
   localparam frame_idx_type POS_CRC_LO   = 5'd16;
   localparam frame_idx_type POS_CRC_HI   = 5'd17;
   localparam frame_idx_type POS_TRL_FAM  = 5'd18;
   localparam frame_idx_type POS_TRL_SYNC = 5'd19;

   function automatic crc_type crc_byte(input crc_type crc_in, input byte_type data);
      crc_type c;
      c = crc_in ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: design/periodic_heartbeat_framer_crc16.sv
// ----------------------------------------------------------------------------
// Periodic heartbeat framer with CRC16-CCITT
// Turns millisecond ticks into 20-byte heartbeat frames sent one byte a word.
// ----------------------------------------------------------------------------
// The req channel takes one tick word: tdata carries the millisecond count and
// tuser says whether the sink takes a frame. The csr channel writes the
// period in milliseconds and is always ready.
// A tick is captured in an input register and judged there against the
// stored tick. When the period has elapsed the tick is stored, and if the
// sink accepts, a frame is loaded into the serializer; the first byte shows
// on rsp once the serializer registers have taken the frame.
// The rsp channel then moves one frame byte a word, twenty words a frame,
// with tlast on the final byte. The CRC is built one byte a word as bytes
// one to fifteen leave. Ticks that send nothing pass at one word a cycle
// unless a frame tick waits ahead; a tick that sends a frame waits while
// the previous frame goes out, so it sustains one frame per twenty rsp words.
// When rsp stalls, the current byte holds and req backs up once a frame
// waits in the input register. Reset empties both stages, clears the stored
// tick and sequence number and sets the period to 1000.
// ----------------------------------------------------------------------------
module periodic_heartbeat_framer_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // now_ms [31:0]
   input  logic        req_tuser,   // sink_accepts [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // frame_byte [7:0]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic        s1_valid_ff, s1_valid_in;
   logic [31:0] s1_now_ff;
   logic        s1_acc_ff;
   logic [15:0] period_ff;
   logic [31:0] last_tick_ff;
   logic [31:0] seq_num_ff;
   logic        busy_ff, busy_in;
   phfc_pkg::frame_idx_type idx_ff, idx_in;
   logic [31:0] seq_ff;
   logic [31:0] ts_ff;
   phfc_pkg::crc_type crc_ff;

   logic [31:0] elapsed;
   logic        due;
   logic        out_take;
   logic        out_end;
   logic        load_ok;
   logic        s1_go;
   logic        load_frame;
   logic        req_take;
   phfc_pkg::byte_type out_byte;

   assign elapsed    = s1_now_ff - last_tick_ff;
   assign due        = elapsed >= {16'd0, period_ff};
   assign out_take   = busy_ff && rsp_tready;
   assign out_end    = out_take && (idx_ff == phfc_pkg::POS_TRL_SYNC);
   assign load_ok    = !busy_ff || out_end;
   assign s1_go      = s1_valid_ff && (!(due && s1_acc_ff) || load_ok);
   assign load_frame = s1_go && due && s1_acc_ff;
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load_frame) begin
         busy_in = 1'b1;
         idx_in  = phfc_pkg::POS_SYNC;
      end else if (out_end) begin
         busy_in = 1'b0;
      end else if (out_take) begin
         idx_in = idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         idx_ff       <= phfc_pkg::POS_SYNC;
         period_ff    <= phfc_pkg::PERIOD_RESET;
         last_tick_ff <= 32'd0;
         seq_num_ff   <= 32'd0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         busy_ff     <= busy_in;
         idx_ff      <= idx_in;
         if (csr_valid && csr_ready) begin
            period_ff <= csr_data;
         end
         if (s1_go && due) begin
            last_tick_ff <= s1_now_ff;
         end
         if (load_frame) begin
            seq_num_ff <= seq_num_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_now_ff <= req_tdata;
         s1_acc_ff <= req_tuser;
      end
      if (load_frame) begin
         seq_ff <= seq_num_ff;
         ts_ff  <= 32'(s1_now_ff * phfc_pkg::US_PER_MS);
         crc_ff <= phfc_pkg::CRC_INIT;
      end else if (out_take && (idx_ff inside {[phfc_pkg::POS_FAMILY:phfc_pkg::POS_TS3]})) begin
         crc_ff <= phfc_pkg::crc_byte(crc_ff, out_byte);
      end
   end

   always_comb begin
      case (idx_ff)
         phfc_pkg::POS_SYNC:     out_byte = phfc_pkg::SYNC_BYTE;
         phfc_pkg::POS_FAMILY:   out_byte = phfc_pkg::FAMILY_BYTE;
         phfc_pkg::POS_VERSION:  out_byte = phfc_pkg::VERSION_BYTE;
         phfc_pkg::POS_PING:     out_byte = phfc_pkg::PING_BYTE;
         phfc_pkg::POS_SEQ0:     out_byte = seq_ff[7:0];
         phfc_pkg::POS_SEQ1:     out_byte = seq_ff[15:8];
         phfc_pkg::POS_SEQ2:     out_byte = seq_ff[23:16];
         phfc_pkg::POS_SEQ3:     out_byte = seq_ff[31:24];
         phfc_pkg::POS_TS0:      out_byte = ts_ff[7:0];
         phfc_pkg::POS_TS1:      out_byte = ts_ff[15:8];
         phfc_pkg::POS_TS2:      out_byte = ts_ff[23:16];
         phfc_pkg::POS_TS3:      out_byte = ts_ff[31:24];
         phfc_pkg::POS_CRC_LO:   out_byte = crc_ff[7:0];
         phfc_pkg::POS_CRC_HI:   out_byte = crc_ff[15:8];
         phfc_pkg::POS_TRL_FAM:  out_byte = phfc_pkg::FAMILY_BYTE;
         phfc_pkg::POS_TRL_SYNC: out_byte = phfc_pkg::SYNC_BYTE;
         default:                out_byte = phfc_pkg::ZERO_BYTE;
      endcase
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = out_byte;
   assign rsp_tlast  = idx_ff == phfc_pkg::POS_TRL_SYNC;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= phfc_pkg::POS_TRL_SYNC)
      else $error("frame byte index out of range");

   a_load_start: assert property (@(posedge clock) disable iff (reset)
      load_frame |=> (busy_ff && idx_ff == phfc_pkg::POS_SYNC))
      else $error("frame load did not restart the serializer");

   a_seq_step: assert property (@(posedge clock) disable iff (reset)
      load_frame |=> (seq_num_ff == 32'($past(seq_num_ff) + 32'd1)))
      else $error("sequence number did not advance on a sent frame");

   a_ts_load: assert property (@(posedge clock) disable iff (reset)
      load_frame |=> (ts_ff == 32'($past(s1_now_ff) * phfc_pkg::US_PER_MS)))
      else $error("timestamp not loaded with the tick in microseconds");

endmodule

FILE: tb/tb_periodic_heartbeat_framer_crc16.sv
// ----------------------------------------------------------------------------
// Heartbeat framer testbench
// Sends millisecond tick words and checks every frame byte against a
// predictor of the tick store, sequence count, timestamp and CRC16-CCITT.
// Directed tests cover the reset period, the smallest, largest and zero
// periods, refused frames and counter wrap. Random traffic under several
// periods follows, with random idling on both sides and a long rsp stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int FRAME_LEN      = 20;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct packed {
      phfc_pkg::byte_type data;
      logic               last;
   } frame_word_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data   = '0;

   frame_word_type expected_bytes[$];

   logic [15:0] model_period    = phfc_pkg::PERIOD_RESET;
   logic [31:0] model_last_tick = '0;
   logic [31:0] model_seq       = '0;

   bit          idle_on      = 1'b1;
   int unsigned hold_request = 0;
   int unsigned hold_left    = 0;
   int unsigned quiet        = 0;

   int unsigned failures     = 0;
   int unsigned ticks_sent   = 0;
   int unsigned frames_sent  = 0;
   int unsigned refused      = 0;
   int unsigned period_writes = 0;
   int unsigned bytes_seen   = 0;

   periodic_heartbeat_framer_crc16 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // now_ms [31:0]
      .req_tuser  (req_tuser),    // sink_accepts [0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // frame_byte [7:0]
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic predict_heartbeat(input logic [31:0] now, input logic accepts,
                                    output bit fired);
      phfc_pkg::byte_type f [FRAME_LEN];
      phfc_pkg::crc_type  crc;
      logic [31:0]        ts;
      fired = 1'b0;
      if (now - model_last_tick >= {16'd0, model_period}) begin
         fired = 1'b1;
         model_last_tick = now;
         if (!accepts) begin
            refused++;
         end else begin
            ts = now * phfc_pkg::US_PER_MS;
            foreach (f[i]) f[i] = phfc_pkg::ZERO_BYTE;
            f[phfc_pkg::POS_SYNC]    = phfc_pkg::SYNC_BYTE;
            f[phfc_pkg::POS_FAMILY]  = phfc_pkg::FAMILY_BYTE;
            f[phfc_pkg::POS_VERSION] = phfc_pkg::VERSION_BYTE;
            f[phfc_pkg::POS_PING]    = phfc_pkg::PING_BYTE;
            for (int k = 0; k < 4; k++) begin
               f[phfc_pkg::POS_SEQ0 + k] = model_seq[8*k +: 8];
               f[phfc_pkg::POS_TS0 + k]  = ts[8*k +: 8];
            end
            crc = phfc_pkg::CRC_INIT;
            for (int i = phfc_pkg::POS_FAMILY; i <= phfc_pkg::POS_TS3; i++) begin
               crc = crc ^ {f[i], 8'h00};
               for (int b = 0; b < 8; b++) begin
                  crc = crc[15] ? ({crc[14:0], 1'b0} ^ phfc_pkg::CRC_POLY)
                                : {crc[14:0], 1'b0};
               end
            end
            f[phfc_pkg::POS_CRC_LO]   = crc[7:0];
            f[phfc_pkg::POS_CRC_HI]   = crc[15:8];
            f[phfc_pkg::POS_TRL_FAM]  = phfc_pkg::FAMILY_BYTE;
            f[phfc_pkg::POS_TRL_SYNC] = phfc_pkg::SYNC_BYTE;
            for (int i = 0; i < FRAME_LEN; i++) begin
               expected_bytes.push_back('{data: f[i], last: (i == FRAME_LEN - 1)});
            end
            model_seq++;
            frames_sent++;
         end
      end
   endtask

   task automatic send_tick(input logic [31:0] now, input logic accepts, output bit fired);
      while (idle_on && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= now;
      req_tuser  <= accepts;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
      predict_heartbeat(now, accepts, fired);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      model_period = value;
      period_writes++;
   endtask

   task automatic test_default_period();
      bit fired;
      send_tick(32'd0, 1'b1, fired);
      send_tick(32'd999, 1'b1, fired);
      send_tick(32'd1000, 1'b1, fired);
      send_tick(32'd2000, 1'b0, fired);
      send_tick(32'd2999, 1'b1, fired);
      send_tick(32'd3000, 1'b1, fired);
      send_tick(32'hFFFF_FFFF, 1'b1, fired);
      send_tick(32'd999, 1'b1, fired);
   endtask

   task automatic test_min_period();
      bit fired;
      write_period(16'd1);
      send_tick(model_last_tick, 1'b1, fired);
      send_tick(model_last_tick + 32'd1, 1'b1, fired);
      send_tick(model_last_tick + 32'd1, 1'b0, fired);
      send_tick(model_last_tick + 32'd1, 1'b1, fired);
   endtask

   task automatic test_max_period();
      bit fired;
      write_period(16'hFFFF);
      send_tick(model_last_tick + 32'd65534, 1'b1, fired);
      send_tick(model_last_tick + 32'd65535, 1'b1, fired);
      send_tick(model_last_tick + 32'd65535, 1'b1, fired);
   endtask

   task automatic test_zero_period();
      bit fired;
      write_period(16'd0);
      send_tick(model_last_tick, 1'b1, fired);
      send_tick(model_last_tick, 1'b0, fired);
      send_tick(model_last_tick, 1'b1, fired);
   endtask

   task automatic run_phase(input logic [15:0] period, input int unsigned target,
                            input bit with_idle);
      bit          fired;
      int unsigned count;
      int unsigned pick;
      logic [31:0] delta;
      logic [31:0] now;
      write_period(period);
      idle_on = with_idle;
      count = 0;
      while (count < target) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            delta = $urandom;
         end else if (pick < 35) begin
            delta = {16'd0, period};
         end else if (pick < 45) begin
            delta = {16'd0, period} - 32'd1;
         end else if (pick < 55) begin
            delta = 32'd0;
         end else begin
            delta = $urandom_range(2 * period);
         end
         now = model_last_tick + delta;
         send_tick(now, $urandom_range(99) < 75, fired);
         count++;
      end
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      run_phase(16'd2, 30, 1'b1);
      run_phase(16'd7, 30, 1'b1);
      run_phase(16'($urandom_range(30, 1)), 30, 1'b0);
      run_phase(16'hFFFF, 30, 1'b1);
      run_phase(16'($urandom_range(65535, 1)), 30, 1'b1);
      run_phase(16'd1, 30, 1'b1);
   endtask

   task automatic test_backpressure();
      bit fired;
      write_period(16'd1);
      idle_on = 1'b0;
      hold_request = 300;
      for (int i = 0; i < 10; i++) begin
         send_tick(model_last_tick + 32'd1, 1'b1, fired);
      end
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_on || ($urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      frame_word_type exp_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_seen++;
         if (expected_bytes.size() == 0) begin
            $error("unexpected word: frame_byte %02h last_byte %0b", rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            exp_word = expected_bytes.pop_front();
            if (rsp_tdata !== exp_word.data) begin
               $error("frame_byte: expected %02h, actual %02h", exp_word.data, rsp_tdata);
               failures++;
            end
            if (rsp_tlast !== exp_word.last) begin
               $error("last_byte: expected %0b, actual %0b", exp_word.last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   initial begin
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Timeout after %0d cycles without a handshake", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_default_period();
      test_min_period();
      test_max_period();
      test_zero_period();
      test_random_traffic();
      test_backpressure();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         $error("frame_byte: %0d expected words never arrived", expected_bytes.size());
         failures++;
      end
      $display("Sent %0d ticks under %0d period writes: %0d frames, %0d refused.",
               ticks_sent, period_writes, frames_sent, refused);
      $display("Checked %0d frame words, %0d mismatches.", bytes_seen, failures);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
